// File: hdl/suik_pkg.sv
// Shared constants and types for the sorted unique insert block.
package suik_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_W-1:0]            count_t;

    typedef struct packed {
        logic cmp_en;
        logic occupied;
        logic wr_en;
    } cell_ctl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

// File: hdl/suik_if.sv
// Request channel interfaces for the sorted unique insert block.
interface suik_in_if;
    logic                  valid;
    logic                  ready;
    suik_pkg::value_t      value;
    logic                  restart;

    modport source (output valid, output value, output restart, input ready);
    modport sink   (input valid, input value, input restart, output ready);
endinterface

interface suik_out_if;
    logic                  valid;
    logic                  ready;
    suik_pkg::count_t      distinct_count;
    logic                  was_new;
    logic                  dropped_full;

    modport source (output valid, output distinct_count, output was_new,
                    output dropped_full, input ready);
    modport sink   (input valid, input distinct_count, input was_new,
                    input dropped_full, output ready);
endinterface

// File: hdl/suik_cell.sv
// One storage cell of the sorted chain: entry, compare flags and shift-up logic.
module suik_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  suik_pkg::cell_ctl_t   ctl,
    input  suik_pkg::value_t      value,
    input  suik_pkg::value_t      ins_value,
    input  logic                  prev_lt,
    input  suik_pkg::value_t      prev_entry,
    output suik_pkg::value_t      entry,
    output suik_pkg::cell_flags_t flags
);

    suik_pkg::value_t      entry_reg;
    suik_pkg::cell_flags_t flags_reg;
    suik_pkg::cell_flags_t flags_next;

    always_comb
    begin
        flags_next = flags_reg;
        if (ctl.cmp_en)
        begin
            flags_next.lt = ctl.occupied && (entry_reg < value);
            flags_next.eq = ctl.occupied && (entry_reg == value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // entries below the insert point hold; the insert point takes the new value
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && !flags_reg.lt)
        begin
            entry_reg <= prev_lt ? ins_value : prev_entry;
        end
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

// File: hdl/sorted_unique_insert.sv
// Sorted unique insert: a chain of cells holding an ascending set of distinct signed values.
// For each request, in the accept cycle every cell compares its entry with the value in parallel;
// at commit, once the output register is free or being read, the chain shifts the larger entries
// up one cell and writes the value at its place, after the match flags of all cells are combined.
// The response is held in an output register, so a new request is taken while it waits;
// the next request enters once the current one has been written to that register.
// A value already stored leaves the set unchanged (was_new low); a new value with the store
// full is flagged by dropped_full and not stored. restart empties the set first.
module sorted_unique_insert (
    input  logic       clk,
    input  logic       rst_n,
    suik_in_if.sink    sample,
    suik_out_if.source status
);

    localparam int N = suik_pkg::CAPACITY;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  restart_reg;
    suik_pkg::value_t      value_reg;
    suik_pkg::count_t      count_reg;
    suik_pkg::count_t      count_next;
    suik_pkg::count_t      count_eff;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    suik_pkg::count_t      out_count_reg;
    logic                  out_new_reg;
    logic                  out_drop_reg;

    logic                  accept;
    logic                  commit;
    logic                  eq_any;
    logic                  is_new;
    logic                  full;
    logic                  wr_en;

    suik_pkg::value_t      entry_vec [N];
    suik_pkg::cell_flags_t flag_vec  [N];
    logic [N-1:0]          eq_bits;

    assign sample.ready = !busy_reg;
    assign accept       = sample.valid && !busy_reg;
    assign commit       = busy_reg && (!out_valid_reg || status.ready);

    assign count_eff = restart_reg ? '0 : count_reg;
    assign full      = (count_eff == suik_pkg::COUNT_W'(N));
    assign eq_any    = |eq_bits;
    assign is_new    = !eq_any;
    assign wr_en     = commit && is_new && !full;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            suik_pkg::cell_ctl_t ctl;
            logic                prev_lt;
            suik_pkg::value_t    prev_entry;

            assign ctl.cmp_en   = accept;
            assign ctl.occupied = !sample.restart && (suik_pkg::COUNT_W'(gi) < count_reg);
            assign ctl.wr_en    = wr_en;
            assign eq_bits[gi]  = flag_vec[gi].eq;

            if (gi == 0)
            begin : g_head
                assign prev_lt    = 1'b1;
                assign prev_entry = value_reg;
            end
            else
            begin : g_body
                assign prev_lt    = flag_vec[gi-1].lt;
                assign prev_entry = entry_vec[gi-1];
            end

            suik_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .value      (sample.value),
                .ins_value  (value_reg),
                .prev_lt    (prev_lt),
                .prev_entry (prev_entry),
                .entry      (entry_vec[gi]),
                .flags      (flag_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (commit)
        begin
            busy_next = 1'b0;
        end

        count_next = count_reg;
        if (commit)
        begin
            count_next = wr_en ? count_eff + suik_pkg::count_t'(1) : count_eff;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg   <= sample.value;
            restart_reg <= sample.restart;
        end
        if (commit)
        begin
            out_count_reg <= count_next;
            out_new_reg   <= is_new;
            out_drop_reg  <= is_new && full;
        end
    end

    assign status.valid          = out_valid_reg;
    assign status.distinct_count = out_count_reg;
    assign status.was_new        = out_new_reg;
    assign status.dropped_full   = out_drop_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= suik_pkg::COUNT_W'(N))
        else $error("entry count above capacity");

    a_drop_holds_count : assert property (@(posedge clk) disable iff (!rst_n)
        commit && is_new && full |=> count_reg == suik_pkg::COUNT_W'(N))
        else $error("dropped value changed the count");

    a_dup_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && !status.was_new |-> !status.dropped_full)
        else $error("duplicate flagged as dropped");

    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && !sample.ready)
        else $error("request accepted without entering the chain");

endmodule

// File: dv/sorted_unique_insert_tb.sv
// Testbench for sorted_unique_insert: random and directed requests checked against a software store.
module sorted_unique_insert_tb;

    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 12;

    typedef enum {EP_CLUSTER, EP_FILL, EP_EXTREME, EP_NOISE, EP_SHORT} episode_t;

    typedef struct {
        suik_pkg::count_t cnt;
        logic             was_new;
        logic             dropped;
    } status_t;

    class dedup_scoreboard;
        suik_pkg::value_t entries[suik_pkg::CAPACITY];
        int unsigned      fill;
        status_t          status_q[$];
        int unsigned      errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endfunction

        function int unsigned outstanding();
            return status_q.size();
        endfunction

        // ascending insert, duplicate and full store left unchanged
        function void note_request(suik_pkg::value_t v, logic restart);
            int unsigned pos;
            status_t     st;
            pos = 0;
            if (restart)
                fill = 0;
            while (pos < fill && entries[pos] < v)
                pos++;
            st.was_new = !(pos < fill && entries[pos] == v);
            st.dropped = 1'b0;
            if (st.was_new)
            begin
                if (fill >= suik_pkg::CAPACITY)
                    st.dropped = 1'b1;
                else
                begin
                    for (int i = fill; i > pos; i--)
                        entries[i] = entries[i-1];
                    entries[pos] = v;
                    fill++;
                end
            end
            st.cnt = suik_pkg::count_t'(fill);
            status_q.insert(status_q.size(), st);
        endfunction

        function void check_status(suik_pkg::count_t cnt, logic was_new, logic dropped);
            status_t st;
            if (status_q.size() == 0)
            begin
                report("status with no request pending");
                return;
            end
            st = status_q.pop_front();
            if (cnt !== st.cnt)
                report($sformatf("distinct_count %0d, expected %0d", cnt, st.cnt));
            if (was_new !== st.was_new)
                report($sformatf("was_new %b, expected %b", was_new, st.was_new));
            if (dropped !== st.dropped)
                report($sformatf("dropped_full %b, expected %b", dropped, st.dropped));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    suik_in_if  sample_if ();
    suik_out_if status_if ();

    dedup_scoreboard sb = new();

    sorted_unique_insert uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .status (status_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 96)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    task automatic send(input suik_pkg::value_t v, input logic restart);
        int unsigned gap;
        sample_if.valid   <= 1'b1;
        sample_if.value   <= v;
        sample_if.restart <= restart;
        do
            @(posedge clk);
        while (sample_if.ready !== 1'b1);
        sb.note_request(v, restart);
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        sample_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // response side
    initial
    begin
        int unsigned stall;
        stall = 0;
        status_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (status_if.valid === 1'b1 && status_if.ready === 1'b1)
                sb.check_status(status_if.distinct_count, status_if.was_new,
                                status_if.dropped_full);
            if (stall > 0)
            begin
                stall--;
                status_if.ready <= 1'b0;
            end
            else
            begin
                status_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid === 1'b1 && sample_if.ready === 1'b1) ||
                (status_if.valid === 1'b1 && status_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("** sorted_unique_insert: FAILED **");
        $finish;
    end

    initial
    begin
        suik_pkg::value_t v;
        suik_pkg::value_t base;
        suik_pkg::value_t pool[$];
        suik_pkg::value_t extremes[7];
        logic             rs;
        episode_t         kind;
        int unsigned      len;
        int unsigned      span;
        int unsigned      done;

        extremes[0] = 32'sh8000_0000;
        extremes[1] = 32'sh8000_0001;
        extremes[2] = 32'sh7fff_ffff;
        extremes[3] = 32'sh7fff_fffe;
        extremes[4] = 32'sh0000_0000;
        extremes[5] = 32'shffff_ffff;
        extremes[6] = 32'sh0000_0001;

        rst_n = 1'b0;
        calm  = 1'b0;
        sample_if.valid   <= 1'b0;
        sample_if.value   <= '0;
        sample_if.restart <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty store after reset, duplicates, extremes, restart
        send(32'sh0000_0005, 1'b0);
        send(32'sh0000_0005, 1'b0);
        send(32'sh8000_0000, 1'b0);
        send(32'sh7fff_ffff, 1'b0);
        send(32'shffff_ffff, 1'b0);
        send(32'sh0000_0000, 1'b0);
        send(32'sh0000_0001, 1'b0);
        send(32'sh7fff_ffff, 1'b0);
        send(32'sh8000_0000, 1'b0);
        send(32'shffff_ffff, 1'b0);
        send(32'sh7fff_ffff, 1'b1);
        send(32'sh8000_0001, 1'b0);
        send(32'sh7fff_fffe, 1'b0);
        send(32'sh8000_0000, 1'b0);
        send(32'sh0000_0000, 1'b1);
        send(32'sh0000_0000, 1'b1);
        send(32'shffff_fffe, 1'b0);
        send(32'sh5555_5555, 1'b0);
        send(32'shaaaa_aaaa, 1'b0);
        drain();

        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:    kind = EP_CLUSTER;
                3, 4, 5:    kind = EP_FILL;
                6:          kind = EP_EXTREME;
                7:          kind = EP_NOISE;
                default:    kind = EP_SHORT;
            endcase
            calm = ($urandom_range(0, 4) == 0);
            pool.delete();
            base = $urandom;
            span = $urandom_range(16, 100);
            case (kind)
                EP_CLUSTER: len = $urandom_range(10, 120);
                EP_FILL:    len = $urandom_range(70, 110);
                EP_SHORT:   len = $urandom_range(1, 5);
                default:    len = $urandom_range(5, 30);
            endcase
            for (int i = 0; i < len; i++)
            begin
                if (i == 0)
                    rs = ($urandom_range(0, 4) != 0);
                else if (kind == EP_NOISE)
                    rs = ($urandom_range(0, 9) == 0);
                else if (kind == EP_FILL)
                    rs = 1'b0;
                else
                    rs = ($urandom_range(0, 99) < 2);
                case (kind)
                    EP_CLUSTER:
                        v = base + suik_pkg::value_t'($urandom_range(0, span));
                    EP_FILL:
                    begin
                        if (pool.size() > 0 && $urandom_range(0, 3) == 0)
                            v = pool[$urandom_range(0, pool.size() - 1)];
                        else
                        begin
                            v = $urandom;
                            pool.insert(pool.size(), v);
                        end
                    end
                    EP_EXTREME:
                        v = ($urandom_range(0, 3) != 0) ? extremes[$urandom_range(0, 6)]
                                                        : suik_pkg::value_t'($urandom);
                    default:
                        v = $urandom;
                endcase
                send(v, rs);
                done++;
            end
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d statuses never arrived", sb.outstanding()));

        if (sb.errors == 0)
            $display("** sorted_unique_insert: PASSED **");
        else
            $display("** sorted_unique_insert: FAILED **");
        $finish;
    end

endmodule
